// ----- design/crs_pkg.sv -----
package crs_pkg;

  // coordinate and blend formats
  localparam int COORD_BITS = 20;
  localparam int T_FRAC     = 16;
  localparam int BLEND_W    = T_FRAC + 1;
  localparam int AXES       = 3;
  localparam int PT_W       = AXES * COORD_BITS;
  localparam int FUNC_W     = 2;

  // mode codes (the remaining codes behave as the full form)
  localparam logic [FUNC_W-1:0] FN_NO_PAST   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_NO_FUTURE = 2'd2;

  // internal widths: coefficients, products, rounded products, sums
  localparam int CO_W  = COORD_BITS + 4;
  localparam int PR1_W = CO_W + BLEND_W + 1;
  localparam int R1_W  = PR1_W - T_FRAC;
  localparam int S1_W  = R1_W + 1;
  localparam int PR2_W = S1_W + BLEND_W + 1;
  localparam int R2_W  = PR2_W - T_FRAC;
  localparam int S2_W  = R2_W + 1;
  localparam int PR3_W = S2_W + BLEND_W + 1;
  localparam int R3_W  = PR3_W - T_FRAC - 1;
  localparam int R_W   = R3_W + 1;

  // rounding offsets, half an lsb of the shifted result
  localparam logic signed [PR1_W-1:0] HALF1 = PR1_W'(1) << (T_FRAC - 1);
  localparam logic signed [PR2_W-1:0] HALF2 = PR2_W'(1) << (T_FRAC - 1);
  localparam logic signed [PR3_W-1:0] HALF3 = PR3_W'(1) << T_FRAC;

  // saturation bounds
  localparam logic signed [R_W-1:0] SAT_HI = R_W'((64'd1 << (COORD_BITS - 1)) - 64'd1);
  localparam logic signed [R_W-1:0] SAT_LO = -R_W'(64'd1 << (COORD_BITS - 1));

  // register stages inside one lane
  localparam int LANE_STAGES = 7;

  // pipeline control from the top level to the output stage
  typedef struct packed {
    logic adv;
    logic vld;
  } pipe_ctl_t;

endpackage

// ----- design/crs_ifs.sv -----
interface crs_in_if import crs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [PT_W-1:0]   past_point;
  logic [PT_W-1:0]   start_point;
  logic [PT_W-1:0]   end_point;
  logic [PT_W-1:0]   future_point;
  logic [BLEND_W-1:0] blend;

  modport source (
    output valid, func, past_point, start_point, end_point, future_point, blend,
    input  ready
  );
  modport sink (
    input  valid, func, past_point, start_point, end_point, future_point, blend,
    output ready
  );
endinterface

interface crs_out_if import crs_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PT_W-1:0] curve_point;
  logic            clipped;

  modport source (output valid, curve_point, clipped, input ready);
  modport sink (input valid, curve_point, clipped, output ready);
endinterface

// ----- design/crs_lane.sv -----
module crs_lane import crs_pkg::*; (
  input  logic                         clk,
  input  logic                         adv,
  input  logic [FUNC_W-1:0]            func,
  input  logic signed [COORD_BITS-1:0] p,
  input  logic signed [COORD_BITS-1:0] s,
  input  logic signed [COORD_BITS-1:0] e,
  input  logic signed [COORD_BITS-1:0] f,
  input  logic [BLEND_W-1:0]           t,
  output logic signed [COORD_BITS-1:0] res,
  output logic                         clip
);

  logic signed [CO_W-1:0] pe, se, ee, fe;
  logic signed [CO_W-1:0] a_nxt, b_nxt, c_nxt;

  // stage registers
  logic signed [CO_W-1:0]  a0_r, b0_r, c0_r, s0_r;
  logic [BLEND_W-1:0]      t0_r, t1_r, t2_r, t3_r, t4_r;
  logic signed [CO_W-1:0]  a1_r, b1_r, s1c_r;
  logic signed [CO_W-1:0]  a2_r, s2c_r, a3_r, s3c_r, s4c_r, s5c_r;
  logic signed [PR1_W-1:0] m1_r;
  logic signed [S1_W-1:0]  s1_r;
  logic signed [PR2_W-1:0] m2_r;
  logic signed [S2_W-1:0]  s2_r;
  logic signed [PR3_W-1:0] m3_r;
  logic signed [COORD_BITS-1:0] res_r;
  logic                         clip_r;

  logic signed [PR1_W-1:0] m1_rnd;
  logic signed [PR2_W-1:0] m2_rnd;
  logic signed [PR3_W-1:0] m3_rnd;
  logic signed [R_W-1:0]   sum;
  logic signed [BLEND_W:0] te2, te4, te0;

  assign pe = CO_W'(p);
  assign se = CO_W'(s);
  assign ee = CO_W'(e);
  assign fe = CO_W'(f);

  // coefficients per mode
  always_comb begin
    case (func)
      FN_NO_PAST: begin
        a_nxt = ee - se;
        b_nxt = (ee <<< 2) - ((se <<< 1) + se) - fe;
        c_nxt = (se <<< 1) - ((ee <<< 1) + ee) + fe;
      end
      FN_NO_FUTURE: begin
        a_nxt = ee - pe;
        b_nxt = (pe <<< 1) - ((se <<< 2) + se) + ((ee <<< 1) + ee);
        c_nxt = ((se <<< 1) + se) - (ee <<< 1) - pe;
      end
      default: begin
        a_nxt = ee - pe;
        b_nxt = (pe <<< 1) - ((se <<< 2) + se) + (ee <<< 2) - fe;
        c_nxt = ((se <<< 1) + se) - ((ee <<< 1) + ee) - pe + fe;
      end
    endcase
  end

  // blend as a non-negative signed operand
  assign te0 = signed'({1'b0, t0_r});
  assign te2 = signed'({1'b0, t2_r});
  assign te4 = signed'({1'b0, t4_r});

  // rounding shifts, half toward plus infinity
  assign m1_rnd = (m1_r + HALF1) >>> T_FRAC;
  assign m2_rnd = (m2_r + HALF2) >>> T_FRAC;
  assign m3_rnd = (m3_r + HALF3) >>> (T_FRAC + 1);

  assign sum = R_W'(s5c_r) + R_W'(signed'(m3_rnd[R3_W-1:0]));

  // horner pipeline: multiply, round and add, one step per stage
  always_ff @(posedge clk) begin
    if (adv) begin
      a0_r  <= a_nxt;
      b0_r  <= b_nxt;
      c0_r  <= c_nxt;
      s0_r  <= se;
      t0_r  <= t;

      m1_r  <= PR1_W'(c0_r) * PR1_W'(te0);
      a1_r  <= a0_r;
      b1_r  <= b0_r;
      s1c_r <= s0_r;
      t1_r  <= t0_r;

      s1_r  <= S1_W'(b1_r) + S1_W'(signed'(m1_rnd[R1_W-1:0]));
      a2_r  <= a1_r;
      s2c_r <= s1c_r;
      t2_r  <= t1_r;

      m2_r  <= PR2_W'(s1_r) * PR2_W'(te2);
      a3_r  <= a2_r;
      s3c_r <= s2c_r;
      t3_r  <= t2_r;

      s2_r  <= S2_W'(a3_r) + S2_W'(signed'(m2_rnd[R2_W-1:0]));
      s4c_r <= s3c_r;
      t4_r  <= t3_r;

      m3_r  <= PR3_W'(s2_r) * PR3_W'(te4);
      s5c_r <= s4c_r;

      // saturate to the coordinate range
      if (sum > SAT_HI) begin
        res_r  <= SAT_HI[COORD_BITS-1:0];
        clip_r <= 1'b1;
      end else if (sum < SAT_LO) begin
        res_r  <= SAT_LO[COORD_BITS-1:0];
        clip_r <= 1'b1;
      end else begin
        res_r  <= sum[COORD_BITS-1:0];
        clip_r <= 1'b0;
      end
    end
  end

  assign res  = res_r;
  assign clip = clip_r;

endmodule

// ----- design/crs_merge.sv -----
module crs_merge import crs_pkg::*; (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pipe_ctl_t                        ctl,
  input  logic [AXES-1:0][COORD_BITS-1:0]  lane_res,
  input  logic [AXES-1:0]                  lane_clip,
  crs_out_if.source                        out_res
);

  logic            out_valid_r;
  logic [PT_W-1:0] point_r;
  logic            clipped_r;

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.adv) begin
      out_valid_r <= ctl.vld;
    end
  end

  // pack the axes and combine the clip flags
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      point_r   <= lane_res;
      clipped_r <= |lane_clip;
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.curve_point = point_r;
  assign out_res.clipped     = clipped_r;

endmodule

// ----- design/catmull_rom_spline_eval.sv -----
// Uniform Catmull-Rom spline evaluator, three axes per request.
// in_req carries the mode, four packed points (past, start, end, future)
// and the blend factor; out_res returns the packed interpolated point and
// a flag that is set when any axis saturated. Both channels use a
// valid/ready handshake: a request moves on a rising edge where both are
// high.
// One lane per axis runs a seven-stage Horner pipeline (coefficients,
// three multiply stages each followed by a round-and-add stage, the last
// with saturation); an output register merges the lanes and raises
// out_res.valid. One request is taken every cycle while the receiver
// takes results.
// When out_res.ready is low with a result waiting, the whole pipeline
// holds and in_req.ready drops; nothing is lost or repeated.
// Reset (synchronous, active low) empties the pipeline; the block has no
// configuration and no state between requests.
module catmull_rom_spline_eval import crs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  crs_in_if.sink    in_req,
  crs_out_if.source out_res
);

  logic                            adv;
  logic [LANE_STAGES-1:0]          vld_r;
  logic [AXES-1:0][COORD_BITS-1:0] lane_res;
  logic [AXES-1:0]                 lane_clip;
  pipe_ctl_t                       ctl;

  // pipeline moves whenever the output register is free or being drained
  assign adv          = !out_res.valid || out_res.ready;
  assign in_req.ready = adv;

  // valid bits alongside the lane stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LANE_STAGES-2:0], in_req.valid};
    end
  end

  assign ctl.adv = adv;
  assign ctl.vld = vld_r[LANE_STAGES-1];

  // one lane per axis
  for (genvar ax = 0; ax < AXES; ax++) begin : g_lane
    crs_lane u_lane (
      .clk  (clk),
      .adv  (adv),
      .func (in_req.func),
      .p    (signed'(in_req.past_point[ax*COORD_BITS +: COORD_BITS])),
      .s    (signed'(in_req.start_point[ax*COORD_BITS +: COORD_BITS])),
      .e    (signed'(in_req.end_point[ax*COORD_BITS +: COORD_BITS])),
      .f    (signed'(in_req.future_point[ax*COORD_BITS +: COORD_BITS])),
      .t    (in_req.blend),
      .res  (lane_res[ax]),
      .clip (lane_clip[ax])
    );
  end

  // output register
  crs_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .lane_res  (lane_res),
    .lane_clip (lane_clip),
    .out_res   (out_res)
  );

endmodule

// ----- tb/catmull_rom_spline_eval_test.sv -----
module catmull_rom_spline_eval_test;
  timeunit 1ns;
  timeprecision 1ps;

  import crs_pkg::*;

  // mode codes not named in the package
  localparam logic [FUNC_W-1:0] FN_FULL  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;

  localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic [COORD_BITS-1:0] COORD_ZERO = '0;
  localparam logic [BLEND_W-1:0] BLEND_ONE  = 17'h10000;
  localparam logic [BLEND_W-1:0] BLEND_HALF = 17'h08000;
  localparam logic [BLEND_W-1:0] BLEND_TOP  = 17'h1FFFF;

  localparam int LATENCY      = 8;
  localparam int RANDOM_ITEMS = 1790;
  localparam int MAX_PRINTS   = 60;

  typedef enum int {CK_FULL, CK_SMALL, CK_EDGE} coord_kind_t;

  typedef struct packed {
    logic [PT_W-1:0] curve_point;
    logic            clipped;
  } curve_result_t;

  logic clk;
  logic rst_n;

  crs_in_if  in_req();
  crs_out_if out_res();

  catmull_rom_spline_eval DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_res(out_res)
  );

  curve_result_t expected_points[$];
  int unsigned   mismatch_count = 0;
  bit            src_idle = 1'b1;
  bit            snk_idle = 1'b1;
  int unsigned   sink_hold_req = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // round to nearest, half toward plus infinity
  function automatic longint round_off(input longint v, input int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  // expected point for one request
  function automatic curve_result_t spline_point(
    input logic [FUNC_W-1:0]  fn,
    input logic [PT_W-1:0]    pp,
    input logic [PT_W-1:0]    sp,
    input logic [PT_W-1:0]    ep,
    input logic [PT_W-1:0]    fp,
    input logic [BLEND_W-1:0] bl
  );
    longint p, s, e, f, a, b, c, s1, s2, r, t, hi, lo;
    curve_result_t res;
    res = '0;
    t  = longint'({47'd0, bl});
    hi = (longint'(1) << (COORD_BITS - 1)) - 1;
    lo = -(longint'(1) << (COORD_BITS - 1));
    for (int ax = 0; ax < AXES; ax++) begin
      p = longint'($signed(pp[ax*COORD_BITS +: COORD_BITS]));
      s = longint'($signed(sp[ax*COORD_BITS +: COORD_BITS]));
      e = longint'($signed(ep[ax*COORD_BITS +: COORD_BITS]));
      f = longint'($signed(fp[ax*COORD_BITS +: COORD_BITS]));
      // coefficients per mode
      case (fn)
        FN_NO_PAST: begin
          a = e - s;
          b = 4 * e - 3 * s - f;
          c = 2 * s - 3 * e + f;
        end
        FN_NO_FUTURE: begin
          a = e - p;
          b = 2 * p - 5 * s + 3 * e;
          c = 3 * s - 2 * e - p;
        end
        default: begin
          a = e - p;
          b = 2 * p - 5 * s + 4 * e - f;
          c = 3 * s - 3 * e - p + f;
        end
      endcase
      // horner evaluation, last step also halves
      s1 = b + round_off(c * t, T_FRAC);
      s2 = a + round_off(s1 * t, T_FRAC);
      r  = s + round_off(s2 * t, T_FRAC + 1);
      // clamp to coordinate range
      if (r > hi) begin
        r = hi;
        res.clipped = 1'b1;
      end
      if (r < lo) begin
        r = lo;
        res.clipped = 1'b1;
      end
      res.curve_point[ax*COORD_BITS +: COORD_BITS] = r[COORD_BITS-1:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("%0t ns: %s", $realtime, msg);
  endtask

  // compare one accepted result with the oldest expectation
  task automatic check_result(input logic [PT_W-1:0] got_pt, input logic got_clip);
    curve_result_t want;
    if (expected_points.size() == 0) begin
      report_mismatch($sformatf("result with no request pending: point %h clip %b",
                                got_pt, got_clip));
      return;
    end
    want = expected_points.pop_front();
    if (got_pt !== want.curve_point)
      report_mismatch($sformatf("curve_point got %h want %h", got_pt, want.curve_point));
    if (got_clip !== want.clipped)
      report_mismatch($sformatf("clipped got %b want %b (point %h)",
                                got_clip, want.clipped, want.curve_point));
  endtask

  // result side: random stalls, long hold on demand, check on handshake
  initial begin : result_sink
    int unsigned stall;
    int unsigned hold;
    stall = 0;
    hold = 0;
    out_res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_res.valid && out_res.ready) begin
        check_result(out_res.curve_point, out_res.clipped);
        stall = snk_idle ? $urandom_range(0, 8) : 0;
      end
      if (sink_hold_req != 0) begin
        hold = sink_hold_req;
        sink_hold_req = 0;
      end
      if (!rst_n) begin
        out_res.ready <= 1'b0;
      end else if (hold != 0) begin
        out_res.ready <= 1'b0;
        hold--;
      end else if (stall != 0) begin
        out_res.ready <= 1'b0;
        stall--;
      end else begin
        out_res.ready <= 1'b1;
      end
    end
  end

  // offer one request and wait for its handshake; called at a rising edge
  task automatic send_request(
    input logic [FUNC_W-1:0]  fn,
    input logic [PT_W-1:0]    pp,
    input logic [PT_W-1:0]    sp,
    input logic [PT_W-1:0]    ep,
    input logic [PT_W-1:0]    fp,
    input logic [BLEND_W-1:0] bl
  );
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid        <= 1'b1;
    in_req.func         <= fn;
    in_req.past_point   <= pp;
    in_req.start_point  <= sp;
    in_req.end_point    <= ep;
    in_req.future_point <= fp;
    in_req.blend        <= bl;
    do @(posedge clk); while (!in_req.ready);
    expected_points.push_back(spline_point(fn, pp, sp, ep, fp, bl));
  endtask

  function automatic logic [PT_W-1:0] pack_point(
    input logic [COORD_BITS-1:0] x,
    input logic [COORD_BITS-1:0] y,
    input logic [COORD_BITS-1:0] z
  );
    return {z, y, x};
  endfunction

  function automatic logic [COORD_BITS-1:0] rand_coord(input coord_kind_t kind);
    int v;
    case (kind)
      CK_SMALL: begin
        v = int'($urandom_range(0, 8191)) - 4096;
        return v[COORD_BITS-1:0];
      end
      CK_EDGE: begin
        v = int'($urandom_range(0, 255));
        return $urandom_range(0, 1) ? COORD_MAX - COORD_BITS'(v) : COORD_MIN + COORD_BITS'(v);
      end
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [PT_W-1:0] rand_point(input coord_kind_t kind);
    return pack_point(rand_coord(kind), rand_coord(kind), rand_coord(kind));
  endfunction

  function automatic logic [BLEND_W-1:0] rand_blend();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return BLEND_ONE;
      2: return BLEND_W'($urandom);
      default: return BLEND_W'($urandom_range(0, 65536));
    endcase
  endfunction

  // field extremes, every mode, unused points, extrapolation
  task automatic test_directed();
    logic [PT_W-1:0] pmax, pmin, pzero, pmix;
    pmax  = pack_point(COORD_MAX, COORD_MAX, COORD_MAX);
    pmin  = pack_point(COORD_MIN, COORD_MIN, COORD_MIN);
    pzero = pack_point(COORD_ZERO, COORD_ZERO, COORD_ZERO);
    pmix  = pack_point(COORD_MAX, COORD_MIN, COORD_ZERO);
    send_request(FN_FULL, pzero, pzero, pzero, pzero, '0);
    send_request(FN_FULL, pmax, pmax, pmax, pmax, BLEND_ONE);
    send_request(FN_NO_PAST, pmax, pmax, pmax, pmax, BLEND_ONE);
    send_request(FN_NO_FUTURE, pmax, pmax, pmax, pmax, BLEND_ONE);
    send_request(FN_SPARE, pmax, pmax, pmax, pmax, BLEND_ONE);
    send_request(FN_FULL, pmin, pmin, pmin, pmin, BLEND_HALF);
    // alternating extremes drive the coefficients to their limits
    send_request(FN_FULL, pmax, pmin, pmax, pmin, BLEND_HALF);
    send_request(FN_FULL, pmin, pmax, pmin, pmax, BLEND_HALF);
    send_request(FN_FULL, pmax, pmin, pmax, pmin, BLEND_TOP);
    send_request(FN_NO_PAST, pmin, pmin, pmax, pmin, BLEND_TOP);
    send_request(FN_NO_FUTURE, pmin, pmax, pmin, pmax, BLEND_TOP);
    send_request(FN_SPARE, pmix, pmin, pmix, pmax, BLEND_TOP);
    // tiny and almost-one blend
    send_request(FN_FULL, pmix, pmax, pmin, pmix, 17'h00001);
    send_request(FN_FULL, pmix, pmin, pmax, pmix, 17'h0FFFF);
    // extrapolation past one with small points
    send_request(FN_FULL, rand_point(CK_SMALL), rand_point(CK_SMALL), rand_point(CK_SMALL),
                 rand_point(CK_SMALL), BLEND_TOP);
    send_request(FN_FULL, rand_point(CK_SMALL), rand_point(CK_SMALL), rand_point(CK_SMALL),
                 rand_point(CK_SMALL), 17'h18000);
    // the ignored point carries wild values
    send_request(FN_NO_PAST, pmax, pzero, pmix, pzero, BLEND_HALF);
    send_request(FN_NO_PAST, pmin, pzero, pmix, pzero, BLEND_HALF);
    send_request(FN_NO_FUTURE, pzero, pzero, pmix, pmax, BLEND_HALF);
    send_request(FN_NO_FUTURE, pzero, pzero, pmix, pmin, BLEND_HALF);
    send_request(FN_SPARE, pzero, pmix, pzero, pmix, BLEND_ONE);
  endtask

  // receiver holds off long while the sender keeps offering
  task automatic test_backpressure();
    src_idle = 1'b0;
    sink_hold_req = 80;
    repeat (40)
      send_request(FUNC_W'($urandom_range(0, 3)), rand_point(CK_SMALL), rand_point(CK_SMALL),
                   rand_point(CK_SMALL), rand_point(CK_SMALL), rand_blend());
    src_idle = 1'b1;
  endtask

  // random stream, idling switched per stretch
  task automatic test_random_stream(input int unsigned count);
    coord_kind_t kind;
    int unsigned pick;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 64 == 0) begin
        src_idle = ($urandom_range(0, 3) != 0);
        snk_idle = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 19);
      kind = (pick < 12) ? CK_SMALL : (pick < 17) ? CK_FULL : CK_EDGE;
      send_request(FUNC_W'($urandom_range(0, 3)), rand_point(kind), rand_point(kind),
                   rand_point(kind), rand_point(kind), rand_blend());
    end
    src_idle = 1'b1;
    snk_idle = 1'b1;
  endtask

  // wait for every outstanding result, then a little longer
  task automatic drain_results();
    in_req.valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
  endtask

  // sequence of tests
  initial begin
    rst_n               = 1'b0;
    in_req.valid        = 1'b0;
    in_req.func         = FN_FULL;
    in_req.past_point   = '0;
    in_req.start_point  = '0;
    in_req.end_point    = '0;
    in_req.future_point = '0;
    in_req.blend        = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_random_stream(RANDOM_ITEMS);
    drain_results();
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
